// File: hdl/ocik_pkg.sv
package ocik_pkg;

    // Chassis geometry: three wheels, or four for any other count.
    localparam int WHEEL_COUNT = 4;
    localparam int NUM_WHEELS  = (WHEEL_COUNT == 3) ? 3 : 4;
    localparam int IDX_W       = 2;

    // Register map.
    localparam int  PADDR_W            = 3;
    localparam logic REG_CHASSIS_RADIUS = 1'b0;
    localparam logic [15:0] RADIUS_RESET = 16'd256;

    // Angle constants in hundredths of a degree.
    localparam logic [15:0] QUARTER   = 16'd9000;
    localparam logic [15:0] HALF_TURN = 16'd18000;
    localparam logic [15:0] THREE_Q   = 16'd27000;
    localparam logic [16:0] FULL_TURN = 17'd36000;

    // z = round(t * 2^30 / 9000) = 119304*t + floor((1456*t + 1125) / 2250).
    localparam logic [16:0] Z_BASE_MUL = 17'd119304;
    localparam logic [10:0] Z_REM_MUL  = 11'd1456;
    localparam logic [10:0] Z_REM_BIAS = 11'd1125;
    localparam logic [11:0] Z_DIV      = 12'd2250;
    localparam logic [24:0] Z_RECIP    = 25'd30541989;
    localparam int          Z_RECIP_SH = 36;

    // Odd Taylor coefficients of sin(pi/2 * z), Q2.30.
    localparam logic signed [32:0] C_A1 = 33'sd1686629713;
    localparam logic signed [32:0] C_A3 = -33'sd693598669;
    localparam logic signed [32:0] C_A5 = 33'sd85569306;
    localparam logic signed [32:0] C_A7 = -33'sd5026995;
    localparam logic signed [32:0] C_A9 = 33'sd172272;

    // Sine unit depth in register stages.
    localparam int POLY_LAT = 15;

    // Mixing matrix constants, Q1.15.
    localparam logic signed [16:0] K_SQRT2_2 = 17'sd23170;
    localparam logic signed [16:0] K_SQRT3_2 = 17'sd28378;
    localparam logic signed [16:0] K_HALF    = 17'sd16384;
    localparam logic signed [16:0] K_NEG_ONE = -17'sd32768;

    typedef logic signed [15:0] speed_t;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] spin;
    } cmd_t;

    typedef struct packed {
        logic        neg;
        logic [13:0] t;
    } fold_t;

    // Shift right by sh, rounding to nearest with halves away from zero.
    function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                                 input int unsigned sh);
        logic        neg;
        logic [63:0] m;
        neg = v[63];
        m   = neg ? 64'(-v) : 64'(v);
        m   = (m + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // Reduce an angle in 0..35999 to a first-quadrant offset and a sign.
    function automatic fold_t fold(input logic [15:0] ang);
        fold_t       r;
        logic [15:0] d;
        d = 16'd0;
        priority if (ang >= THREE_Q)
        begin
            d     = ang - THREE_Q;
            r.neg = 1'b1;
            r.t   = 14'(QUARTER - d);
        end
        else if (ang >= HALF_TURN)
        begin
            d     = ang - HALF_TURN;
            r.neg = 1'b1;
            r.t   = 14'(d);
        end
        else if (ang >= QUARTER)
        begin
            d     = ang - QUARTER;
            r.neg = 1'b0;
            r.t   = 14'(QUARTER - d);
        end
        else
        begin
            r.neg = 1'b0;
            r.t   = 14'(ang);
        end
        return r;
    endfunction

    // Horner coefficient for step k, after the leading A9.
    function automatic logic signed [32:0] horner_coef(input int k);
        logic signed [32:0] c;
        priority if (k == 0)
            c = C_A7;
        else if (k == 1)
            c = C_A5;
        else if (k == 2)
            c = C_A3;
        else
            c = C_A1;
        return c;
    endfunction

    // Weight of bx for wheel i.
    function automatic logic signed [16:0] coef_x(input int i);
        logic signed [16:0] c;
        if (NUM_WHEELS == 3)
        begin
            c = (i == 0) ? K_NEG_ONE : K_HALF;
        end
        else
        begin
            c = (i < 2) ? K_SQRT2_2 : -K_SQRT2_2;
        end
        return c;
    endfunction

    // Weight of by for wheel i.
    function automatic logic signed [16:0] coef_y(input int i);
        logic signed [16:0] c;
        if (NUM_WHEELS == 3)
        begin
            priority if (i == 0)
                c = 17'sd0;
            else if (i == 1)
                c = -K_SQRT3_2;
            else
                c = K_SQRT3_2;
        end
        else
        begin
            c = (i[0] == 1'b0) ? K_SQRT2_2 : -K_SQRT2_2;
        end
        return c;
    endfunction

endpackage

// File: hdl/ocik_poly.sv
module ocik_poly (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [13:0]        in_t,
    input  logic               in_neg,
    output logic               out_valid,
    output logic signed [15:0] out_val
);
    import ocik_pkg::*;

    logic [POLY_LAT-1:0]  vld_reg;
    logic                 neg_reg [0:13];
    logic [23:0]          x_reg;
    logic [30:0]          base_reg;
    logic [23:0]          x1_reg;
    logic [30:0]          base1_reg;
    logic [12:0]          qe_reg;
    logic [30:0]          z_reg [2:12];
    logic [61:0]          zz_reg;
    logic [30:0]          z2_reg [4:10];
    logic signed [63:0]   m_reg [0:3];
    logic signed [32:0]   p_reg [0:3];
    logic signed [63:0]   mz_reg;
    logic signed [15:0]   out_reg;

    logic [48:0]          qe_prod;
    logic [23:0]          rem;
    logic [30:0]          z_next;
    logic signed [63:0]   r_round;
    logic signed [63:0]   r_next;
    logic signed [15:0]   out_next;

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[POLY_LAT-2:0], in_valid};
    end

    // Reciprocal estimate of the remainder quotient, then one correction.
    assign qe_prod = 49'(x_reg) * 49'(Z_RECIP);
    assign rem     = x1_reg - (24'(qe_reg) * 24'(Z_DIV));
    assign z_next  = base1_reg + 31'(qe_reg) + ((rem >= 24'(Z_DIV)) ? 31'd1 : 31'd0);

    // Quadrant scaling of the angle into Q2.30 and the square.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= in_neg;
            x_reg      <= (24'(in_t) * 24'(Z_REM_MUL)) + 24'(Z_REM_BIAS);
            base_reg   <= 31'(in_t) * 31'(Z_BASE_MUL);
            qe_reg     <= 13'(qe_prod >> Z_RECIP_SH);
            x1_reg     <= x_reg;
            base1_reg  <= base_reg;
            z_reg[2]   <= z_next;
            zz_reg     <= 62'(z_reg[2]) * 62'(z_reg[2]);
            z2_reg[4]  <= 31'((zz_reg + 62'd536870912) >> 30);
        end
    end

    // Carry lines for the sign, z and z squared.
    genvar j;
    generate
        for (j = 1; j <= 13; j++)
        begin : g_neg
            always_ff @(posedge clk)
            begin
                if (en)
                    neg_reg[j] <= neg_reg[j-1];
            end
        end
        for (j = 3; j <= 12; j++)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (en)
                    z_reg[j] <= z_reg[j-1];
            end
        end
        for (j = 5; j <= 10; j++)
        begin : g_z2
            always_ff @(posedge clk)
            begin
                if (en)
                    z2_reg[j] <= z2_reg[j-1];
            end
        end
    endgenerate

    // Horner steps: one multiply stage and one round-and-add stage each.
    genvar k;
    generate
        for (k = 0; k < 4; k++)
        begin : g_horner
            logic signed [32:0] p_in;
            if (k == 0)
            begin : g_first
                assign p_in = C_A9;
            end
            else
            begin : g_rest
                assign p_in = p_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[k] <= 64'(p_in) * 64'($signed({1'b0, z2_reg[4+2*k]}));
                    p_reg[k] <= horner_coef(k) + 33'(rnd64(m_reg[k], 30));
                end
            end
        end
    endgenerate

    // Final multiply by z, round to Q1.15, clamp and apply the quadrant sign.
    assign r_round = rnd64(rnd64(mz_reg, 30), 15);

    always_comb
    begin
        priority if (r_round < 64'sd0)
            r_next = 64'sd0;
        else if (r_round > 64'sd32767)
            r_next = 64'sd32767;
        else
            r_next = r_round;
        out_next = neg_reg[13] ? -16'(r_next) : 16'(r_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mz_reg  <= 64'(p_reg[3]) * 64'($signed({1'b0, z_reg[12]}));
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[POLY_LAT-1];
    assign out_val   = out_reg;

endmodule

// File: hdl/ocik_sincos.sv
module ocik_sincos (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ocik_pkg::cmd_t     in_cmd,
    input  logic signed [15:0] in_yaw,
    output logic               out_valid,
    output logic signed [15:0] out_sin,
    output logic signed [15:0] out_cos,
    output ocik_pkg::cmd_t     out_cmd
);
    import ocik_pkg::*;

    logic        v0_reg;
    logic        v1_reg;
    logic [15:0] ang_reg;
    logic [15:0] cang_reg;
    fold_t       fs_reg;
    fold_t       fc_reg;
    cmd_t        cmd0_reg;
    cmd_t        cmd_reg [0:POLY_LAT];

    logic [15:0] ang_next;
    logic [15:0] cang_next;
    logic        sin_valid;
    logic        cos_valid;

    // Bring the angle into 0..35999 and form the cosine angle.
    assign ang_next  = in_yaw[15] ? 16'(17'($signed(in_yaw)) + FULL_TURN) : 16'(in_yaw);
    assign cang_next = (ang_next >= THREE_Q) ? ang_next - THREE_Q : ang_next + QUARTER;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    // Angle reduction, then quadrant folding.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg    <= ang_next;
            cang_reg   <= cang_next;
            cmd0_reg   <= in_cmd;
            fs_reg     <= fold(ang_reg);
            fc_reg     <= fold(cang_reg);
            cmd_reg[0] <= cmd0_reg;
        end
    end

    // The velocity command rides alongside the sine units.
    genvar j;
    generate
        for (j = 1; j <= POLY_LAT; j++)
        begin : g_cmd
            always_ff @(posedge clk)
            begin
                if (en)
                    cmd_reg[j] <= cmd_reg[j-1];
            end
        end
    endgenerate

    ocik_poly u_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_t      (fs_reg.t),
        .in_neg    (fs_reg.neg),
        .out_valid (sin_valid),
        .out_val   (out_sin)
    );

    ocik_poly u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_t      (fc_reg.t),
        .in_neg    (fc_reg.neg),
        .out_valid (cos_valid),
        .out_val   (out_cos)
    );

    assign out_valid = sin_valid & cos_valid;
    assign out_cmd   = cmd_reg[POLY_LAT];

endmodule

// File: hdl/ocik_mix.sv
module ocik_mix (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [15:0]     in_sin,
    input  logic signed [15:0]     in_cos,
    input  ocik_pkg::cmd_t         in_cmd,
    input  logic [15:0]            radius,
    output logic                   out_valid,
    output ocik_pkg::speed_t       out_speed [ocik_pkg::NUM_WHEELS],
    output logic                   out_sat [ocik_pkg::NUM_WHEELS]
);
    import ocik_pkg::*;

    logic [4:0]         vld_reg;
    logic signed [31:0] cvx_reg;
    logic signed [31:0] svy_reg;
    logic signed [31:0] cvy_reg;
    logic signed [31:0] svx_reg;
    logic signed [32:0] wp_reg;
    logic signed [17:0] bx_reg;
    logic signed [17:0] by_reg;
    logic signed [24:0] w1_reg;
    logic signed [24:0] w2_reg;
    logic signed [34:0] px_reg [NUM_WHEELS];
    logic signed [34:0] py_reg [NUM_WHEELS];
    logic signed [26:0] sum_reg [NUM_WHEELS];
    speed_t             spd_reg [NUM_WHEELS];
    logic               sat_reg [NUM_WHEELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    // Rotation products and the spin term, then rounding to Q7.8.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cvx_reg <= in_cos * in_cmd.vx;
            svy_reg <= in_sin * in_cmd.vy;
            cvy_reg <= in_cos * in_cmd.vy;
            svx_reg <= in_sin * in_cmd.vx;
            wp_reg  <= in_cmd.spin * $signed({1'b0, radius});
            bx_reg  <= 18'(rnd64(64'(cvx_reg) + 64'(svy_reg), 15));
            by_reg  <= 18'(rnd64(64'(cvy_reg) - 64'(svx_reg), 15));
            w1_reg  <= 25'(rnd64(64'(wp_reg), 8));
            w2_reg  <= w1_reg;
        end
    end

    // One lane per wheel: weighted products, rounded sum, then clipping.
    genvar i;
    generate
        for (i = 0; i < NUM_WHEELS; i++)
        begin : g_wheel
            logic signed [26:0] sum_next;
            assign sum_next = 27'(rnd64(64'(px_reg[i]) + 64'(py_reg[i]), 15)) + 27'(w2_reg);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    px_reg[i]  <= bx_reg * coef_x(i);
                    py_reg[i]  <= by_reg * coef_y(i);
                    sum_reg[i] <= sum_next;
                    priority if (sum_reg[i] > 27'sd32767)
                    begin
                        spd_reg[i] <= 16'sh7FFF;
                        sat_reg[i] <= 1'b1;
                    end
                    else if (sum_reg[i] < -27'sd32768)
                    begin
                        spd_reg[i] <= 16'sh8000;
                        sat_reg[i] <= 1'b1;
                    end
                    else
                    begin
                        spd_reg[i] <= 16'(sum_reg[i]);
                        sat_reg[i] <= 1'b0;
                    end
                end
            end

            assign out_speed[i] = spd_reg[i];
            assign out_sat[i]   = sat_reg[i];
        end
    endgenerate

    assign out_valid = vld_reg[4];

endmodule

// File: hdl/ocik_ser.sv
module ocik_ser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  ocik_pkg::speed_t             in_speed [ocik_pkg::NUM_WHEELS],
    input  logic                         in_sat [ocik_pkg::NUM_WHEELS],
    output logic                         load_ok,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ocik_pkg::IDX_W-1:0]   out_index,
    output ocik_pkg::speed_t             out_speed,
    output logic                         out_sat,
    output logic                         out_last
);
    import ocik_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WHEELS - 1);

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    speed_t           spd_reg [NUM_WHEELS];
    logic             sat_reg [NUM_WHEELS];
    logic             load;

    // A new set of wheel speeds loads once the last one of the previous set goes.
    assign load_ok = !busy_reg || (out_ready && (idx_reg == LAST_IDX));
    assign load    = in_valid && load_ok;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        priority if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (idx_reg == LAST_IDX)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            spd_reg <= in_speed;
            sat_reg <= in_sat;
        end
    end

    assign out_valid = busy_reg;
    assign out_index = idx_reg;
    assign out_speed = spd_reg[idx_reg];
    assign out_sat   = sat_reg[idx_reg];
    assign out_last  = (idx_reg == LAST_IDX);

endmodule

// File: hdl/omni_chassis_inverse_kinematics.sv
// Omni-wheel chassis inverse kinematics. Each command on the input stream
// (vx, vy, spin in signed Q7.8 and yaw in hundredths of a degree) is rotated
// into the body frame, mixed with the spin scaled by chassis_radius, and
// leaves as one wheel speed transfer per wheel in wheel order, the last one
// marked by tlast and any clipped speed flagged in tuser. The datapath is a
// 22-stage pipeline followed by an output register and can take a command
// every cycle while it is not stalled; the single output stream then sets the
// rate, as it sends the wheels of a command one after another, and the whole
// pipeline stalls while its last stage holds a set the output cannot take. The
// only register, chassis_radius (unsigned Q8.8, reset 1.0), sits at address 0
// of the APB port and may be written only while no command is in flight.
module omni_chassis_inverse_kinematics (
    input  logic                                clk,
    input  logic                                rst_n,
    // Command stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // target_vx[15:0], target_vy[31:16], target_spin[47:32], yaw[63:48]
    input  logic [63:0]                         s_tdata,
    // Wheel speed stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // wheel_index[1:0], speed[17:2], zero[23:18]
    output logic [23:0]                         m_tdata,
    // saturated[0]
    output logic                                m_tuser,
    output logic                                m_tlast,
    // Configuration.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ocik_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import ocik_pkg::*;

    logic               adv;
    logic               accept;
    cmd_t               in_cmd;
    logic               sc_valid;
    logic signed [15:0] sc_sin;
    logic signed [15:0] sc_cos;
    cmd_t               sc_cmd;
    logic               mix_valid;
    speed_t             mix_speed [NUM_WHEELS];
    logic               mix_sat [NUM_WHEELS];
    logic               load_ok;
    logic [IDX_W-1:0]   wheel_index;
    speed_t             out_rate;
    logic [15:0]        radius_reg;
    logic               reg_sel;

    // Register port.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_CHASSIS_RADIUS);
    assign prdata  = reg_sel ? {16'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (psel && penable && pwrite && pready && reg_sel)
            radius_reg <= pwdata[15:0];
    end

    // The whole pipeline moves unless its tail holds a set the output cannot take.
    assign adv      = !mix_valid || load_ok;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    assign in_cmd.vx   = s_tdata[15:0];
    assign in_cmd.vy   = s_tdata[31:16];
    assign in_cmd.spin = s_tdata[47:32];

    ocik_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (accept),
        .in_cmd    (in_cmd),
        .in_yaw    (s_tdata[63:48]),
        .out_valid (sc_valid),
        .out_sin   (sc_sin),
        .out_cos   (sc_cos),
        .out_cmd   (sc_cmd)
    );

    ocik_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sc_valid),
        .in_sin    (sc_sin),
        .in_cos    (sc_cos),
        .in_cmd    (sc_cmd),
        .radius    (radius_reg),
        .out_valid (mix_valid),
        .out_speed (mix_speed),
        .out_sat   (mix_sat)
    );

    ocik_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_speed  (mix_speed),
        .in_sat    (mix_sat),
        .load_ok   (load_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (wheel_index),
        .out_speed (out_rate),
        .out_sat   (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'd0, out_rate, wheel_index};

endmodule

// File: hdl/ocik_chk.sv
module ocik_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import ocik_pkg::*;

    // The last wheel of a command carries the highest wheel number.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[1:0] == 2'(NUM_WHEELS - 1)))
        else $error("tlast on a wheel other than the last");

    // Wheels of one command follow each other in order without a gap in numbering.
    a_next_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && (m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1)))
        else $error("wheel sequence broken");

    // A new command starts at wheel zero.
    a_first_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) ##1 m_tvalid |-> (m_tdata[1:0] == 2'd0))
        else $error("command did not start at wheel zero");

    // A clipped speed sits at one of the limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
        ((m_tdata[17:2] == 16'h7FFF) || (m_tdata[17:2] == 16'h8000)))
        else $error("saturated speed not at a limit");

endmodule

bind omni_chassis_inverse_kinematics ocik_chk u_ocik_chk (.*);
